>>> design/fpp_pkg.sv
package fpp_pkg;

   localparam int BYTE_W    = 8;
   localparam int TIME_W    = 32;
   localparam int INDEX_W   = 5;
   localparam int LENGTH_W  = 6;
   localparam int CSR_IDX_W = 3;
   localparam int RUN_CAP   = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POSE_ID      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_LEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ID      = 3'd4;

   // Register reset values
   localparam logic [BYTE_W-1:0]   START_FIRST_RST  = 8'd170;
   localparam logic [BYTE_W-1:0]   START_SECOND_RST = 8'd85;
   localparam logic [BYTE_W-1:0]   POSE_ID_RST      = 8'd1;
   localparam logic [LENGTH_W-1:0] EXPECTED_LEN_RST = 6'd16;
   localparam logic [BYTE_W-1:0]   NODE_ID_RST      = 8'd0;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic [TIME_W-1:0] now_time_ms;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  payload_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               last_byte;
      logic [TIME_W-1:0]  frame_time_ms;
      logic [BYTE_W-1:0]  source_robot;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   start_byte_first;
      logic [BYTE_W-1:0]   start_byte_second;
      logic [BYTE_W-1:0]   pose_message_id;
      logic [LENGTH_W-1:0] expected_length;
      logic [BYTE_W-1:0]   node_id;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;       // back to hunting: drop id, length, count, checksum
      logic load_id;     // take the id byte
      logic load_len;    // take the length byte
      logic store_byte;  // write a payload byte into the store
      logic capture;     // latch frame time and robot id, rewind replay index
      logic read_issue;  // read the store at the replay index
      logic out_load;    // load the result register and advance the index
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_first;
      logic is_second;
      logic len_bad;
      logic payload_done;
      logic check_ok;
      logic run_last;
      logic out_free;
   } status_type;

endpackage

>>> design/fpp_csr.sv
module fpp_csr
   import fpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; ignore indexes past the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_FIRST:  cfg_in.start_byte_first  = csr_data;
            CSR_START_SECOND: cfg_in.start_byte_second = csr_data;
            CSR_POSE_ID:      cfg_in.pose_message_id   = csr_data;
            CSR_EXPECTED_LEN: cfg_in.expected_length   = csr_data[LENGTH_W-1:0];
            CSR_NODE_ID:      cfg_in.node_id           = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte_first  <= START_FIRST_RST;
         cfg_ff.start_byte_second <= START_SECOND_RST;
         cfg_ff.pose_message_id   <= POSE_ID_RST;
         cfg_ff.expected_length   <= EXPECTED_LEN_RST;
         cfg_ff.node_id           <= NODE_ID_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/fpp_ctrl.sv
module fpp_ctrl
   import fpp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_START1,
      ST_START2,
      ST_ID,
      ST_LEN,
      ST_PAYLOAD,
      ST_CHECK,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      stall_ff;
   logic      stall_in;
   logic      accept;

   assign req_stall = stall_ff;
   assign accept    = req_valid && !stall_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_START1: begin
            if (accept && status.is_first) begin
               state_in = ST_START2;
            end
         end
         ST_START2: begin
            if (accept) begin
               if (status.is_second) begin
                  state_in = ST_ID;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = ST_START1;
               end
            end
         end
         ST_ID: begin
            if (accept) begin
               cmd.load_id = 1'b1;
               state_in    = ST_LEN;
            end
         end
         ST_LEN: begin
            if (accept) begin
               if (status.len_bad) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_START1;
               end else begin
                  cmd.load_len = 1'b1;
                  state_in     = ST_PAYLOAD;
               end
            end
         end
         ST_PAYLOAD: begin
            if (accept) begin
               cmd.store_byte = 1'b1;
               if (status.payload_done) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (accept) begin
               // Keep the frame length for the replay; clear once it ends
               if (status.check_ok) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_READ;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = ST_START1;
               end
            end
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.run_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_START1;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            cmd.clear = 1'b1;
            state_in  = ST_START1;
         end
      endcase
   end

   // Hold the input side while the payload is replayed
   always_comb begin
      stall_in = (state_in == ST_READ) || (state_in == ST_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START1;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

endmodule

>>> design/fpp_dpath.sv
module fpp_dpath
   import fpp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
)(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);
   localparam logic [BYTE_W-1:0] CAP_LEN = BYTE_W'(RUN_CAP);

   logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

   logic [BYTE_W-1:0] id_ff,   id_in;
   logic [CNT_W-1:0]  len_ff,  len_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [BYTE_W-1:0] xor_ff,  xor_in;
   logic [ADDR_W-1:0] run_ff,  run_in;
   logic [TIME_W-1:0] time_ff;
   logic [BYTE_W-1:0] robot_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   logic [BYTE_W-1:0] rx;
   logic [BYTE_W-1:0] run_cnt;

   assign rx        = req_data.rx_byte;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Replay length: the frame length, cut at the result index range
   assign run_cnt = (BYTE_W'(len_ff) > CAP_LEN) ? CAP_LEN : BYTE_W'(len_ff);

   // Status towards the controller
   always_comb begin
      status.is_first     = (rx == cfg.start_byte_first);
      status.is_second    = (rx == cfg.start_byte_second);
      status.len_bad      = (rx == '0) || (rx > MAX_LEN);
      status.payload_done = (BYTE_W'(cnt_ff) + BYTE_W'(1)) >= BYTE_W'(len_ff);
      status.check_ok     = (rx == xor_ff) && (id_ff == cfg.pose_message_id) &&
                            (BYTE_W'(len_ff) == BYTE_W'(cfg.expected_length));
      status.run_last     = (BYTE_W'(run_ff) + BYTE_W'(1)) == run_cnt;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // Frame bookkeeping
   always_comb begin
      id_in  = id_ff;
      len_in = len_ff;
      cnt_in = cnt_ff;
      xor_in = xor_ff;
      run_in = run_ff;
      if (cmd.clear) begin
         id_in  = '0;
         len_in = '0;
         cnt_in = '0;
         xor_in = '0;
      end
      if (cmd.load_id) begin
         id_in  = rx;
         xor_in = rx;
      end
      if (cmd.load_len) begin
         len_in = CNT_W'(rx);
         xor_in = xor_ff ^ rx;
         cnt_in = '0;
      end
      if (cmd.store_byte) begin
         cnt_in = cnt_ff + CNT_W'(1);
         xor_in = xor_ff ^ rx;
      end
      if (cmd.capture) begin
         run_in = '0;
      end
      if (cmd.out_load) begin
         run_in = run_ff + ADDR_W'(1);
      end
   end

   // Result register: drop valid once the transfer completes
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff        <= '0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         xor_ff       <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         id_ff        <= id_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         xor_ff       <= xor_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Frame time and robot tag at the checksum byte
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         time_ff  <= req_data.now_time_ms;
         robot_ff <= cfg.node_id;
      end
   end

   // Payload store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         mem[cnt_ff[ADDR_W-1:0]] <= rx;
      end
      if (cmd.read_issue) begin
         rd_data_ff <= mem[run_ff];
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.payload_byte  <= rd_data_ff;
         rsp_ff.byte_index    <= INDEX_W'(run_ff);
         rsp_ff.last_byte     <= status.run_last;
         rsp_ff.frame_time_ms <= time_ff;
         rsp_ff.source_robot  <= robot_ff;
      end
   end

endmodule

>>> design/framed_packet_parser_unit.sv
// Channel   Ports                                    Transfer when
// request   req_valid, req_stall, req_data           req_valid && !req_stall
// response  rsp_valid, rsp_stall, rsp_data           rsp_valid && !rsp_stall
// config    csr_valid, csr_ready, csr_index, csr_data csr_valid && csr_ready
//
// Each received byte takes one cycle while a frame is parsed.
// A matching checksum byte with the expected id and length starts the replay:
// per byte a store read, then a result load, longer while rsp_stall is high.
// req_stall is high for the whole replay and low again once the last result
// sits in the result register. Reset is synchronous and puts the parser back
// to hunting for the first start byte with the registers at their reset values.
module framed_packet_parser_unit
   import fpp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   fpp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpp_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
